// ===== design/swr_pkg.sv =====
// Shared constants, types and command/status bundles for the sampling block.
package swr_pkg;

	localparam int MAX_POPULATION = 256;
	localparam int IDX_W          = $clog2(MAX_POPULATION);
	localparam int CNT_W          = IDX_W + 1;
	localparam int WORD_W         = 31;
	localparam int TDATA_IN_W     = ((WORD_W + 7) / 8) * 8;
	localparam int TDATA_OUT_W    = ((IDX_W + 7) / 8) * 8;
	localparam int DIV_CNT_W      = $clog2(WORD_W);
	localparam int CFG_W          = 9;
	localparam int APB_ADDR_W     = 3;
	localparam int APB_DATA_W     = 32;

	// register select: bit 2 of paddr
	localparam logic REG_POP_SIZE     = 1'b0;
	localparam logic REG_NUM_SELECTED = 1'b1;

	localparam logic [CFG_W-1:0] POP_SIZE_RST     = CFG_W'(256);
	localparam logic [CFG_W-1:0] NUM_SELECTED_RST = CFG_W'(16);

	typedef struct packed {
		logic start;
		logic div_step;
		logic scan_step;
		logic commit;
	} swr_cmd_t;

	typedef struct packed {
		logic div_last;
		logic scan_done;
	} swr_sts_t;

endpackage

// ===== design/swr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module swr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== design/swr_ctrl.sv =====
// Controller: sequences modulo, duplicate scan and commit; owns the stream handshakes.
module swr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  swr_pkg::swr_sts_t sts,
	output swr_pkg::swr_cmd_t cmd
);
	import swr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:   cmd.start     = s_tvalid;
			ST_DIV:    cmd.div_step  = 1'b1;
			ST_SCAN:   cmd.scan_step = 1'b1;
			ST_COMMIT: cmd.commit    = out_free;
			default:   cmd           = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if ((state_q == ST_COMMIT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (sts.div_last) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.scan_done) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/swr_dp.sv =====
// Datapath: clamps, bit-serial modulo, store of chosen indices, scan and result register.
module swr_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [swr_pkg::CFG_W-1:0]    pop_size,
	input  logic [swr_pkg::CFG_W-1:0]    num_selected,
	input  logic [swr_pkg::WORD_W-1:0]   random_word,
	input  swr_pkg::swr_cmd_t            cmd,
	output swr_pkg::swr_sts_t            sts,
	output logic [swr_pkg::IDX_W-1:0]    chosen_index,
	output logic                         last
);
	import swr_pkg::*;

	logic [CNT_W-1:0]     n_eff, k_eff, pos_eff, j_full, pos_next;
	logic [CNT_W-1:0]     pos_q, t_q;
	logic [IDX_W-1:0]     j_q, pick;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W:0]       trial, divisor;
	logic                 trial_ge;
	logic [WORD_W-1:0]    word_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 pend_s1, seen_q;
	logic [IDX_W-1:0]     rd_data;
	logic [IDX_W-1:0]     chosen_q;
	logic                 last_q;

	// population saturated to 1..MAX_POPULATION, count to 1..N
	always_comb begin
		n_eff = pop_size;
		if (pop_size == '0) begin
			n_eff = CNT_W'(1);
		end else if (pop_size > CNT_W'(MAX_POPULATION)) begin
			n_eff = CNT_W'(MAX_POPULATION);
		end
		k_eff = num_selected;
		if (num_selected == '0) begin
			k_eff = CNT_W'(1);
		end else if (num_selected > n_eff) begin
			k_eff = n_eff;
		end
	end

	assign pos_eff  = (pos_q >= k_eff) ? '0 : pos_q;
	assign j_full   = n_eff - k_eff + pos_eff;
	assign pos_next = pos_q + CNT_W'(1);

	// restoring division, one quotient bit per cycle; remainder stays below j+1
	assign divisor  = {1'b0, CNT_W'(j_q) + CNT_W'(1)};
	assign trial    = {rem_q, word_q[WORD_W-1]};
	assign trial_ge = (trial >= divisor);

	assign pick = seen_q ? j_q : rem_q[IDX_W-1:0];

	assign sts.div_last  = (div_cnt_q == '0);
	assign sts.scan_done = (t_q >= pos_q) && !pend_s1;

	swr_ram #(
		.WIDTH (IDX_W),
		.DEPTH (MAX_POPULATION)
	) u_store (
		.clk     (clk),
		.wr_en   (cmd.commit),
		.wr_addr (pos_q[IDX_W-1:0]),
		.wr_data (pick),
		.rd_addr (t_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			if (cmd.start) begin
				pos_q   <= pos_eff;
				pend_s1 <= 1'b0;
			end else if (cmd.scan_step) begin
				pend_s1 <= (t_q < pos_q);
			end
			if (cmd.commit) begin
				pos_q <= (pos_next >= k_eff) ? '0 : pos_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			j_q       <= j_full[IDX_W-1:0];
			word_q    <= random_word;
			rem_q     <= '0;
			div_cnt_q <= DIV_CNT_W'(WORD_W - 1);
			t_q       <= '0;
			seen_q    <= 1'b0;
		end else begin
			if (cmd.div_step) begin
				rem_q     <= trial_ge ? CNT_W'(trial - divisor) : CNT_W'(trial);
				word_q    <= {word_q[WORD_W-2:0], 1'b0};
				div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
			end
			if (cmd.scan_step && (t_q < pos_q)) begin
				t_q <= t_q + CNT_W'(1);
			end
			if (pend_s1 && (rd_data == rem_q[IDX_W-1:0])) begin
				seen_q <= 1'b1;
			end
		end
		if (cmd.commit) begin
			chosen_q <= pick;
			last_q   <= (pos_next >= k_eff);
		end
	end

	assign chosen_index = chosen_q;
	assign last         = last_q;

endmodule

// ===== design/sample_without_replacement_top.sv =====
// Per input transaction: the 31-step serial modulo, then the walk over the i stored indices
// (i = draw position) through the single RAM read port, then the commit of the result.
// A new input transaction is taken only once the previous one is committed.
// A result waiting on the output register does not block the next input transaction.
// Reset (arst_n low, asynchronous): draw position 0, pop_size 256, num_selected 16;
// the index store is not cleared.
module sample_without_replacement_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [swr_pkg::TDATA_IN_W-1:0]    s_tdata,   // [30:0] random_word
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [swr_pkg::TDATA_OUT_W-1:0]   m_tdata,   // [7:0] chosen_index
	output logic                              m_tlast,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [swr_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [swr_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [swr_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);
	import swr_pkg::*;

	logic [CFG_W-1:0] pop_size_q, num_selected_q;
	logic             cfg_wr;
	logic [IDX_W-1:0] chosen_index;
	swr_cmd_t         cmd;
	swr_sts_t         sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_size_q     <= POP_SIZE_RST;
			num_selected_q <= NUM_SELECTED_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_POP_SIZE:     pop_size_q     <= pwdata[CFG_W-1:0];
				REG_NUM_SELECTED: num_selected_q <= pwdata[CFG_W-1:0];
				default:          pop_size_q     <= pop_size_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_POP_SIZE:     prdata = APB_DATA_W'(pop_size_q);
			REG_NUM_SELECTED: prdata = APB_DATA_W'(num_selected_q);
			default:          prdata = '0;
		endcase
	end

	swr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	swr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_size     (pop_size_q),
		.num_selected (num_selected_q),
		.random_word  (s_tdata[WORD_W-1:0]),
		.cmd          (cmd),
		.sts          (sts),
		.chosen_index (chosen_index),
		.last         (m_tlast)
	);

	assign m_tdata = TDATA_OUT_W'(chosen_index);

endmodule

// ===== design/swr_chk.sv =====
// Port-level checker for the sampling block, bound to the top level.
module swr_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [swr_pkg::TDATA_OUT_W-1:0]   m_tdata,
	input logic                              m_tlast
);
	import swr_pkg::*;

	// one item in flight: input closes after each transaction
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in progress");

	// a fresh result only comes out of a busy period
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without an item being worked on");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

endmodule

bind sample_without_replacement_top swr_chk u_swr_chk (.*);

// ===== bench/testbench.sv =====
// Testbench for sample_without_replacement_top: stream traffic, APB setup and a Floyd draw predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import swr_pkg::*;

	localparam logic [APB_ADDR_W-1:0] ADDR_POP_SIZE     = {REG_POP_SIZE, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_NUM_SELECTED = {REG_NUM_SELECTED, 2'b00};
	localparam int RANDOM_ITEMS = 1425;
	localparam int HOLD_CYCLES  = 1500;
	localparam int STALL_LIMIT  = 20000;
	localparam int IDLE_SETTLE  = 8;
	localparam int END_SETTLE   = 300;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic             last;
	} pick_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [TDATA_IN_W-1:0]   s_tdata = '0;     // [30:0] random_word
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0]  m_tdata;          // [7:0] chosen_index
	logic                    m_tlast;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [APB_ADDR_W-1:0]   paddr = '0;
	logic [APB_DATA_W-1:0]   pwdata = '0;
	logic [APB_DATA_W-1:0]   prdata;
	logic                    pready;

	// predictor state
	logic [CFG_W-1:0]        cfg_features = POP_SIZE_RST;
	logic [CFG_W-1:0]        cfg_selected = NUM_SELECTED_RST;
	int unsigned             draw_pos = 0;
	logic [IDX_W-1:0]        drawn [MAX_POPULATION];

	logic [WORD_W-1:0]       random_backlog [$];
	pick_t                   expected_picks [$];
	int                      mismatches = 0;
	int                      stall_cycles = 0;
	bit                      s_taken = 1'b0;
	int                      send_idle_pct = 19;
	int                      recv_idle_pct = 57;
	int                      holds_asked = 0;
	int                      holds_served = 0;
	int                      hold_left = 0;

	sample_without_replacement_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
	end

	function automatic pick_t floyd_pick(input logic [WORD_W-1:0] word);
		int unsigned n, k, j, r, sel;
		bit seen;
		pick_t p;
		n = cfg_features;
		if (n < 1) n = 1;
		if (n > MAX_POPULATION) n = MAX_POPULATION;
		k = cfg_selected;
		if (k < 1) k = 1;
		if (k > n) k = n;
		if (draw_pos >= k) draw_pos = 0;
		j = n - k + draw_pos;
		r = word % (j + 1);
		seen = 1'b0;
		for (int t = 0; t < draw_pos; t++) begin
			if (drawn[t] == r) seen = 1'b1;
		end
		sel = seen ? j : r;
		drawn[draw_pos] = IDX_W'(sel);
		draw_pos++;
		p.index = IDX_W'(sel);
		p.last = (draw_pos >= k);
		if (p.last) draw_pos = 0;
		return p;
	endfunction

	function automatic logic [WORD_W-1:0] random_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: return WORD_W'($urandom_range(0, 600));
			default: return WORD_W'($urandom());
		endcase
	endfunction

	task automatic log_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
	endtask

	task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [CFG_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= APB_DATA_W'(val);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_read_check(input logic [APB_ADDR_W-1:0] addr, input logic [CFG_W-1:0] val);
		logic [APB_DATA_W-1:0] got;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got[CFG_W-1:0] !== val)
			log_mismatch($sformatf("register read at %0d: expected %0d, got %0d",
				addr, val, got[CFG_W-1:0]));
	endtask

	task automatic set_config(input logic [CFG_W-1:0] n, input logic [CFG_W-1:0] k);
		apb_write(ADDR_POP_SIZE, n);
		apb_write(ADDR_NUM_SELECTED, k);
		apb_read_check(ADDR_POP_SIZE, n);
		apb_read_check(ADDR_NUM_SELECTED, k);
	endtask

	// block is idle once nothing is queued, offered or outstanding
	task automatic wait_idle();
		while (random_backlog.size() != 0 || s_tvalid || expected_picks.size() != 0)
			@(negedge clk);
		repeat (IDLE_SETTLE) @(negedge clk);
	endtask

	// input driver
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_taken) begin
			if (random_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= TDATA_IN_W'(random_backlog.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output ready, with an occasional long hold-off
	always @(negedge clk) begin
		if (holds_asked != holds_served) begin
			hold_left = HOLD_CYCLES;
			holds_served = holds_asked;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor: predict on input transactions, check output transactions
	always @(posedge clk) begin : monitor
		pick_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_picks.size() == 0) begin
					log_mismatch($sformatf("unexpected result idx %0d last %0b",
						m_tdata, m_tlast));
				end else begin
					want = expected_picks.pop_front();
					if (m_tdata !== want.index || m_tlast !== want.last)
						log_mismatch($sformatf("expected idx %0d last %0b, got idx %0d last %0b",
							want.index, want.last, m_tdata, m_tlast));
				end
			end
			if (s_tvalid && s_tready)
				expected_picks.push_back(floyd_pick(s_tdata[WORD_W-1:0]));
			s_taken = s_tvalid && s_tready;
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_POP_SIZE) cfg_features = pwdata[CFG_W-1:0];
				else if (paddr == ADDR_NUM_SELECTED) cfg_selected = pwdata[CFG_W-1:0];
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			    (expected_picks.size() == 0 && random_backlog.size() == 0 && !s_tvalid))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int n_cfg, k_cfg, eff_n, eff_k, draws, count, phase, random_items;
		random_items = 0;
		phase = 0;
		while (!arst_n) @(negedge clk);
		repeat (2) @(negedge clk);
		apb_read_check(ADDR_POP_SIZE, POP_SIZE_RST);
		apb_read_check(ADDR_NUM_SELECTED, NUM_SELECTED_RST);

		// reset population and count, word extremes
		random_backlog.push_back('0);
		random_backlog.push_back('1);
		wait_idle();
		// mid-draw change to N=K=4: finishes the draw, then all-zero words force repeats
		set_config(4, 4);
		repeat (6) random_backlog.push_back('0);
		wait_idle();
		// single index population, zero count
		set_config(1, 0);
		random_backlog.push_back('1);
		random_backlog.push_back(WORD_W'(32'h2AAA_AAAA));
		wait_idle();
		set_config(0, 5);
		random_backlog.push_back(WORD_W'(32'h5555_5555));
		wait_idle();
		// population above the maximum saturates
		set_config(511, 2);
		random_backlog.push_back('1);
		random_backlog.push_back('0);
		wait_idle();
		// count above population
		set_config(3, 9);
		repeat (3) random_backlog.push_back(WORD_W'(5));
		wait_idle();
		// count lowered below the position mid-draw restarts the draw
		set_config(8, 6);
		repeat (3) random_backlog.push_back(random_word());
		wait_idle();
		set_config(8, 2);
		repeat (3) random_backlog.push_back(random_word());
		wait_idle();
		// count raised mid-draw carries on
		set_config(8, 4);
		repeat (3) random_backlog.push_back(random_word());
		wait_idle();

		while (random_items < RANDOM_ITEMS) begin
			if (random_items >= 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (random_items >= RANDOM_ITEMS / 3) begin
				send_idle_pct = 57;
				recv_idle_pct = 19;
			end
			case (phase)
				0: begin n_cfg = 256; k_cfg = 256; end
				1: begin n_cfg = 256; k_cfg = 1; end
				2: begin n_cfg = 511; k_cfg = 0; end
				3: begin n_cfg = 64; k_cfg = 8; end
				default: begin
					case ($urandom_range(9))
						0: n_cfg = $urandom_range(129, 256);
						1: n_cfg = $urandom_range(257, 511);
						2: n_cfg = $urandom_range(0, 2);
						default: n_cfg = $urandom_range(2, 40);
					endcase
					eff_n = (n_cfg < 1) ? 1 : (n_cfg > MAX_POPULATION) ? MAX_POPULATION : n_cfg;
					case ($urandom_range(9))
						0: k_cfg = 0;
						1: k_cfg = $urandom_range(eff_n, 511);
						default: k_cfg = $urandom_range(1, (eff_n < 24) ? eff_n : 24);
					endcase
				end
			endcase
			eff_n = (n_cfg < 1) ? 1 : (n_cfg > MAX_POPULATION) ? MAX_POPULATION : n_cfg;
			eff_k = (k_cfg < 1) ? 1 : (k_cfg > eff_n) ? eff_n : k_cfg;
			if (eff_k > 24) draws = 1;
			else if (eff_k <= 4) draws = $urandom_range(4, 12);
			else draws = $urandom_range(1, 4);
			if (phase == 3) draws = 3;
			count = draws * eff_k;
			// leave some draws unfinished so the next setup lands mid-draw
			if ($urandom_range(3) == 0) count += $urandom_range(0, eff_k - 1);
			wait_idle();
			set_config(CFG_W'(n_cfg), CFG_W'(k_cfg));
			for (int i = 0; i < count; i++) random_backlog.push_back(random_word());
			random_items += count;
			// output held off while input keeps coming, so the block backs up
			if (phase == 3) holds_asked++;
			phase++;
		end

		wait_idle();
		repeat (END_SETTLE) @(negedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
